@@ design/napa_pkg.sv @@
// Shared widths, codes and parameter defaults of the pixel aggregator.
`default_nettype none

package napa_pkg;

  localparam int PIXELS_DEF = 4096;
  localparam int LAYERS_DEF = 16;

  localparam int CMD_W   = 1;
  localparam int LAYER_W = 4;
  localparam int PIXEL_W = 12;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 16;
  localparam int MODE_W  = 2;

  localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MEAN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MIN  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_MAX  = 2'd3;

  localparam logic [CMD_W-1:0] CMD_ACCUM = 1'b0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 1'b1;

endpackage

`default_nettype wire

@@ design/napa_ifs.sv @@
// Channel interfaces of the pixel aggregator: samples in, results out, mode writes.
`default_nettype none

interface napa_sample_if;
  import napa_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic [LAYER_W-1:0]        layer_index;
  logic [PIXEL_W-1:0]        pixel_index;
  logic signed [VALUE_W-1:0] sample_value;
  logic                      sample_valid;

  modport source(output valid, command, layer_index, pixel_index, sample_value,
                 sample_valid, input ready);
  modport sink(input valid, command, layer_index, pixel_index, sample_value,
               sample_valid, output ready);
endinterface

interface napa_result_if;
  import napa_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] result_value;
  logic                      result_valid;
  logic [COUNT_W-1:0]        result_count;

  modport source(output valid, result_value, result_valid, result_count, input ready);
  modport sink(input valid, result_value, result_valid, result_count, output ready);
endinterface

interface napa_mode_if;
  import napa_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;

  modport source(output valid, mode, input ready);
  modport sink(input valid, mode, output ready);
endinterface

`default_nettype wire

@@ design/nodata_aware_pixel_aggregator.sv @@
// Per-location no-data aware aggregator (overwrite, running mean, minimum, maximum).
//
// Usage: items arrive on sample_in and each one produces exactly one transfer on
// result_out holding the location's value, valid flag and count after the item.
// The aggregation mode is written on mode_cfg, which is always ready; write it
// only while no item is in flight. One item is processed at a time: sample_in is
// ready only while the sequencer is idle.
// An accepted item steps through address, read and evaluate to the done step, where
// its result is loaded, for overwrite, minimum, maximum, clear, out-of-range and
// no-data items. For a running-mean fold, one 32x17 multiply is followed by a sum
// step and a 32-step radix-2 divider that produces one quotient bit per cycle. After
// the result is loaded the sequencer returns to idle and accepts the next item.
// Reset: the mode returns to overwrite, and a clearing pass empties the count memory
// one entry per cycle, LAYERS*PIXELS entries (65536 by default), while sample_in
// stays not ready; mode writes are accepted during the pass.
// A stalled receiver holds the result register; the next item may be accepted
// and processed meanwhile, and waits in its final step until the register frees.
`default_nettype none

module nodata_aware_pixel_aggregator #(
  parameter int PIXELS = napa_pkg::PIXELS_DEF,
  parameter int LAYERS = napa_pkg::LAYERS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  napa_sample_if.sink   sample_in,
  napa_result_if.source result_out,
  napa_mode_if.sink     mode_cfg
);
  import napa_pkg::*;

  localparam int DEPTH      = LAYERS * PIXELS;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PROD_W     = VALUE_W + COUNT_W + 1;
  localparam int DVSR_W     = COUNT_W + 1;
  localparam int DIV_STEPS  = VALUE_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ADDR  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_EVAL  = 3'd4;
  localparam logic [2:0] S_SUM   = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]                state;
  logic [MODE_W-1:0]         mode;
  logic [ADDR_W-1:0]         clr_addr;

  logic [CMD_W-1:0]          cmd_q;
  logic [LAYER_W-1:0]        layer_q;
  logic [PIXEL_W-1:0]        pixel_q;
  logic signed [VALUE_W-1:0] sample_q;
  logic                      svalid_q;
  logic [ADDR_W-1:0]         addr;
  logic                      in_range;

  logic signed [VALUE_W-1:0] rd_val;
  logic [COUNT_W-1:0]        rd_cnt;
  logic signed [VALUE_W-1:0] new_val;
  logic [COUNT_W-1:0]        new_cnt;
  logic                      wr_en;
  logic                      mean_pend;

  logic signed [PROD_W-1:0]  prod;
  logic                      neg;
  logic [DVSR_W-1:0]         dvsr;
  logic [DVSR_W-1:0]         rem;
  logic [VALUE_W-1:0]        quo;
  logic [DIV_CNT_W-1:0]      div_cnt;

  logic                      out_valid;
  logic signed [VALUE_W-1:0] out_value;
  logic                      out_dvalid;
  logic [COUNT_W-1:0]        out_count;

  logic signed [VALUE_W-1:0] agg_mem [DEPTH];
  logic [COUNT_W-1:0]        cnt_mem [DEPTH];

  logic                      in_xfer;
  logic                      out_free;
  logic                      commit;
  logic                      old_valid;
  logic                      go_mean;
  logic [COUNT_W-1:0]        cnt_sat;
  logic signed [PROD_W-1:0]  sum;
  logic [PROD_W-1:0]         mag;
  logic [DVSR_W:0]           trial;
  logic [DVSR_W:0]           diff;
  logic                      ge;
  logic signed [VALUE_W-1:0] final_val;

  assign sample_in.ready = (state == S_IDLE);
  assign mode_cfg.ready  = 1'b1;
  assign in_xfer         = sample_in.valid && sample_in.ready;
  assign out_free        = !out_valid || result_out.ready;
  assign commit          = (state == S_DONE) && out_free;

  assign result_out.valid        = out_valid;
  assign result_out.result_value = out_value;
  assign result_out.result_valid = out_dvalid;
  assign result_out.result_count = out_count;

  assign old_valid = (rd_cnt != '0);
  assign cnt_sat   = (rd_cnt == '1) ? rd_cnt : rd_cnt + COUNT_W'(1);
  assign go_mean   = in_range && (cmd_q == CMD_ACCUM) && svalid_q && old_valid &&
                     (mode == MODE_MEAN);

  assign sum   = prod + {{(PROD_W-VALUE_W){sample_q[VALUE_W-1]}}, sample_q};
  assign mag   = sum[PROD_W-1] ? PROD_W'(-sum) : PROD_W'(sum);
  assign trial = {rem, quo[VALUE_W-1]};
  assign diff  = trial - {1'b0, dvsr};
  assign ge    = (trial >= {1'b0, dvsr});

  assign final_val = !mean_pend ? new_val :
                     (neg ? -$signed(quo) : $signed(quo));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      mode     <= MODE_NONE;
    end else begin
      if (mode_cfg.valid && mode_cfg.ready) begin
        mode <= mode_cfg.mode;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            state <= S_ADDR;
          end
        end
        S_ADDR: state <= S_READ;
        S_READ: state <= S_EVAL;
        S_EVAL: state <= go_mean ? S_SUM : S_DONE;
        S_SUM:  state <= S_DIV;
        S_DIV: begin
          if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_q    <= sample_in.command;
      layer_q  <= sample_in.layer_index;
      pixel_q  <= sample_in.pixel_index;
      sample_q <= sample_in.sample_value;
      svalid_q <= sample_in.sample_valid;
    end
    if (state == S_ADDR) begin
      addr     <= ADDR_W'(32'(layer_q) * PIXELS + 32'(pixel_q));
      in_range <= (32'(layer_q) < LAYERS) && (32'(pixel_q) < PIXELS);
    end
    if (state == S_EVAL) begin
      prod      <= rd_val * $signed({1'b0, rd_cnt});
      dvsr      <= {1'b0, rd_cnt} + DVSR_W'(1);
      mean_pend <= go_mean;
      if (!in_range) begin
        wr_en   <= 1'b0;
        new_val <= rd_val;
        new_cnt <= '0;
      end else if (cmd_q == CMD_CLEAR) begin
        wr_en   <= 1'b1;
        new_val <= rd_val;
        new_cnt <= '0;
      end else if (!svalid_q) begin
        wr_en   <= 1'b0;
        new_val <= rd_val;
        new_cnt <= rd_cnt;
      end else if (!old_valid) begin
        wr_en   <= 1'b1;
        new_val <= sample_q;
        new_cnt <= COUNT_W'(1);
      end else begin
        wr_en   <= 1'b1;
        new_cnt <= cnt_sat;
        unique case (mode)
          MODE_NONE: new_val <= sample_q;
          MODE_MEAN: new_val <= rd_val;
          MODE_MIN:  new_val <= (sample_q < rd_val) ? sample_q : rd_val;
          MODE_MAX:  new_val <= (sample_q > rd_val) ? sample_q : rd_val;
        endcase
      end
    end
    if (state == S_SUM) begin
      neg     <= sum[PROD_W-1];
      rem     <= mag[PROD_W-1:VALUE_W];
      quo     <= mag[VALUE_W-1:0];
      div_cnt <= '0;
    end
    if (state == S_DIV) begin
      rem     <= ge ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
      quo     <= {quo[VALUE_W-2:0], ge};
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_READ && in_range) begin
      rd_val <= agg_mem[addr];
    end
    if (commit && wr_en) begin
      agg_mem[addr] <= final_val;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_READ && in_range) begin
      rd_cnt <= cnt_mem[addr];
    end
    if (state == S_CLEAR) begin
      cnt_mem[clr_addr] <= '0;
    end else if (commit && wr_en) begin
      cnt_mem[addr] <= new_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_dvalid <= (new_cnt != '0);
      out_count  <= new_cnt;
      out_value  <= (new_cnt != '0) ? final_val : '0;
    end
  end

`ifndef SYNTHESIS
  a_accept_starts_item: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> state == S_ADDR)
    else $error("accepted item did not start address computation");

  a_valid_matches_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_dvalid == (out_count != '0)))
    else $error("result valid flag disagrees with result count");

  a_nodata_reads_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_dvalid) |-> out_value == '0)
    else $error("no-data result carries a nonzero value");

  a_div_ends_in_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) |=> state == S_DONE)
    else $error("divider did not finish after its last step");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !out_valid)
    else $error("result presented during the clearing pass");
`endif

endmodule

`default_nettype wire
